// ----- rtl/sdr_pkg.sv -----
// ---------------------------------------------------------------------------
// sdr_pkg: shared types and constants of the door ramp controller
// Holds field widths, ramp constants, the configuration and result structs.
// ---------------------------------------------------------------------------
package sdr_pkg;

	localparam int PHASE_BITS  = 2;
	localparam int DECEL_STEPS = 8;

	localparam int PERIOD_W    = 8;
	localparam int POS_W       = 16;
	localparam int IDX_W       = 5;
	localparam int PHASE_OUT_W = 2;
	localparam int MOTION_W    = 2;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 6;

	typedef struct packed {
		logic [63:0]        accel_periods;
		logic [PERIOD_W-1:0] cruise_period;
		logic [63:0]        decel_periods;
		logic [POS_W-1:0]   far_position;
		logic [POS_W-1:0]   closed_position;
	} sdr_cfg_t;

	typedef struct packed {
		logic                   step_taken;
		logic [PHASE_OUT_W-1:0] phase;
		logic                   current_on;
		logic [POS_W-1:0]       position;
		logic [MOTION_W-1:0]    motion;
	} sdr_result_t;

endpackage

// ----- rtl/sdr_channels.sv -----
// ---------------------------------------------------------------------------
// sdr_channels: valid/ready channels of the door ramp controller
// Command channel (one tick with an optional command) and result channel.
// ---------------------------------------------------------------------------
interface sdr_cmd_if;
	logic valid;
	logic ready;
	logic cmd_valid;
	logic cmd_open;

	modport source (output valid, output cmd_valid, output cmd_open, input ready);
	modport sink   (input valid, input cmd_valid, input cmd_open, output ready);
endinterface

interface sdr_res_if;
	logic        valid;
	logic        ready;
	logic        step_taken;
	logic [1:0]  phase;
	logic        current_on;
	logic [15:0] position;
	logic [1:0]  motion;

	modport source (output valid, output step_taken, output phase, output current_on,
		output position, output motion, input ready);
	modport sink   (input valid, input step_taken, input phase, input current_on,
		input position, input motion, output ready);
endinterface

// ----- rtl/sdr_apb_regs.sv -----
// ---------------------------------------------------------------------------
// sdr_apb_regs: APB configuration registers
// Five registers at byte address 8*i, 64-bit data, always ready.
// ---------------------------------------------------------------------------
module sdr_apb_regs
	import sdr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output sdr_cfg_t              cfg
);

	localparam logic [2:0] REG_ACCEL  = 3'd0;
	localparam logic [2:0] REG_CRUISE = 3'd1;
	localparam logic [2:0] REG_DECEL  = 3'd2;
	localparam logic [2:0] REG_FAR    = 3'd3;
	localparam logic [2:0] REG_HOME   = 3'd4;

	localparam logic [POS_W-1:0] FAR_RESET = POS_W'(10000);

	sdr_cfg_t   cfg_q;
	logic [2:0] reg_sel;
	logic       wr_en;

	assign reg_sel = paddr[CFG_ADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_periods   <= '0;
			cfg_q.cruise_period   <= '0;
			cfg_q.decel_periods   <= '0;
			cfg_q.far_position    <= FAR_RESET;
			cfg_q.closed_position <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_ACCEL:  cfg_q.accel_periods   <= pwdata;
				REG_CRUISE: cfg_q.cruise_period   <= pwdata[PERIOD_W-1:0];
				REG_DECEL:  cfg_q.decel_periods   <= pwdata;
				REG_FAR:    cfg_q.far_position    <= pwdata[POS_W-1:0];
				REG_HOME:   cfg_q.closed_position <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ACCEL:  prdata = cfg_q.accel_periods;
			REG_CRUISE: prdata = CFG_DATA_W'(cfg_q.cruise_period);
			REG_DECEL:  prdata = cfg_q.decel_periods;
			REG_FAR:    prdata = CFG_DATA_W'(cfg_q.far_position);
			REG_HOME:   prdata = CFG_DATA_W'(cfg_q.closed_position);
			default:    prdata = '0;
		endcase
	end

endmodule

// ----- rtl/sdr_ramp_core.sv -----
// ---------------------------------------------------------------------------
// sdr_ramp_core: ramp state and per-tick update
// Holds the run state and computes the next state and result of one tick.
// ---------------------------------------------------------------------------
module sdr_ramp_core
	import sdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sdr_cfg_t    cfg,
	input  logic        advance,
	input  logic        cmd_valid,
	input  logic        cmd_open,
	output sdr_result_t result
);

	typedef enum logic [1:0] {
		SPD_HOLD  = 2'd0,
		SPD_ACC   = 2'd1,
		SPD_CONST = 2'd2,
		SPD_DEC   = 2'd3
	} speed_t;

	typedef enum logic [1:0] {
		RUN_HOLD  = 2'd0,
		RUN_OPEN  = 2'd1,
		RUN_CLOSE = 2'd2
	} run_t;

	localparam int TGT_W = 18;
	localparam int CMP_W = 20;

	localparam logic [IDX_W-1:0] RAMP_CRUISE = IDX_W'(8);
	localparam logic [IDX_W-1:0] DECEL_BASE  = IDX_W'(9);
	localparam logic [IDX_W-1:0] RAMP_LAST   = IDX_W'(16);

	localparam logic signed [TGT_W:0]   TWO_DEC = (TGT_W+1)'(2 * DECEL_STEPS);
	localparam logic signed [CMP_W-1:0] DEC_C   = CMP_W'(DECEL_STEPS);

	logic                    pending_q, req_dir_q, cur_dir_q, armed_q, current_q;
	speed_t                  speed_q;
	run_t                    run_q;
	logic [IDX_W-1:0]        idx_q;
	logic [PERIOD_W-1:0]     tick_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [TGT_W-1:0] tgt_q;

	logic                    pending_d, req_dir_d, cur_dir_d, armed_d, current_d;
	speed_t                  speed_d;
	run_t                    run_d;
	logic [IDX_W-1:0]        idx_d;
	logic [PERIOD_W-1:0]     tick_d;
	logic [PHASE_BITS-1:0]   phase_d;
	logic [POS_W-1:0]        pos_d;
	logic signed [TGT_W-1:0] tgt_d;
	logic                    step_d;
	logic                    expire;
	logic                    do_step;
	logic signed [TGT_W:0]   pos_s, idx_s;
	logic signed [CMP_W-1:0] pos_c, tgt_c;

	function automatic logic [PERIOD_W-1:0] period_at(input sdr_cfg_t c,
		input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0]    k;
		logic [IDX_W-1:0]    d;
		logic [PERIOD_W-1:0] p;
		k = (i > RAMP_LAST) ? RAMP_LAST : i;
		d = k - DECEL_BASE;
		if (k < RAMP_CRUISE) begin
			p = c.accel_periods[{k[2:0], 3'b000} +: PERIOD_W];
		end else if (k == RAMP_CRUISE) begin
			p = c.cruise_period;
		end else begin
			p = c.decel_periods[{d[2:0], 3'b000} +: PERIOD_W];
		end
		return p;
	endfunction

	assign pos_s = $signed({3'b000, pos_q});
	assign idx_s = $signed({{(TGT_W+1-IDX_W){1'b0}}, idx_q});
	assign pos_c = $signed({4'b0000, pos_q});

	always_comb begin
		pending_d = pending_q;
		req_dir_d = req_dir_q;
		cur_dir_d = cur_dir_q;
		armed_d   = armed_q;
		current_d = current_q;
		speed_d   = speed_q;
		run_d     = run_q;
		idx_d     = idx_q;
		phase_d   = phase_q;
		pos_d     = pos_q;
		tgt_d     = tgt_q;
		step_d    = 1'b0;
		do_step   = 1'b0;
		tgt_c     = '0;

		// latch a new command and advance the tick counter
		if (cmd_valid) begin
			pending_d = 1'b1;
			req_dir_d = cmd_open;
		end
		tick_d = tick_q + PERIOD_W'(1);

		// reverse arming, start from hold or retarget to a stop
		if (pending_d) begin
			if (req_dir_d != cur_dir_q) begin
				if (!armed_q) begin
					armed_d = 1'b1;
				end else if (speed_q == SPD_HOLD) begin
					tgt_d     = req_dir_d ? TGT_W'(cfg.far_position)
						: TGT_W'(cfg.closed_position);
					cur_dir_d = req_dir_d;
					pending_d = 1'b0;
					run_d     = req_dir_d ? RUN_OPEN : RUN_CLOSE;
					speed_d   = SPD_ACC;
					idx_d     = '0;
				end else if (run_q == RUN_OPEN) begin
					tgt_d = TGT_W'(pos_s + TWO_DEC - idx_s);
				end else if (run_q == RUN_CLOSE) begin
					tgt_d = TGT_W'(pos_s - TWO_DEC + idx_s);
				end
			end else begin
				armed_d = 1'b0;
			end
		end

		expire = (tick_d >= period_at(cfg, idx_d));
		if (expire) begin
			tgt_c = CMP_W'(tgt_d);
			case (speed_d)
				SPD_ACC: begin
					idx_d = idx_d + IDX_W'(1);
					if (idx_d >= RAMP_CRUISE) begin
						speed_d = SPD_CONST;
						idx_d   = RAMP_CRUISE;
					end
					current_d = 1'b1;
					do_step   = 1'b1;
				end
				SPD_CONST: begin
					if (cur_dir_d && (pos_c >= tgt_c - DEC_C))
						speed_d = SPD_DEC;
					if (!cur_dir_d && (pos_c <= tgt_c + DEC_C))
						speed_d = SPD_DEC;
					current_d = 1'b1;
					do_step   = 1'b1;
				end
				SPD_DEC: begin
					idx_d = idx_d + IDX_W'(1);
					if (idx_d >= RAMP_LAST) begin
						speed_d = SPD_HOLD;
						run_d   = RUN_HOLD;
						idx_d   = RAMP_LAST;
					end
					current_d = 1'b1;
					do_step   = 1'b1;
				end
				default: begin
					speed_d   = SPD_HOLD;
					run_d     = RUN_HOLD;
					idx_d     = '0;
					current_d = 1'b0;
				end
			endcase
			tick_d = '0;
		end

		// issue a phase step in the run direction; none without a direction
		if (do_step) begin
			case (run_d)
				RUN_OPEN: begin
					phase_d = phase_q + PHASE_BITS'(1);
					if (pos_q != '1)
						pos_d = pos_q + POS_W'(1);
					step_d = 1'b1;
				end
				RUN_CLOSE: begin
					phase_d = phase_q - PHASE_BITS'(1);
					if (pos_q != '0)
						pos_d = pos_q - POS_W'(1);
					step_d = 1'b1;
				end
				default: ;
			endcase
		end

		result.step_taken = step_d;
		result.phase      = PHASE_OUT_W'(phase_d);
		result.current_on = current_d;
		result.position   = pos_d;
		result.motion     = speed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			req_dir_q <= 1'b0;
			cur_dir_q <= 1'b0;
			armed_q   <= 1'b0;
			current_q <= 1'b0;
			speed_q   <= SPD_HOLD;
			run_q     <= RUN_HOLD;
			idx_q     <= '0;
			tick_q    <= '0;
			phase_q   <= '0;
			pos_q     <= '0;
			tgt_q     <= '0;
		end else if (advance) begin
			pending_q <= pending_d;
			req_dir_q <= req_dir_d;
			cur_dir_q <= cur_dir_d;
			armed_q   <= armed_d;
			current_q <= current_d;
			speed_q   <= speed_d;
			run_q     <= run_d;
			idx_q     <= idx_d;
			tick_q    <= tick_d;
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			tgt_q     <= tgt_d;
		end
	end

	a_hold_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(speed_q == SPD_HOLD) == (run_q == RUN_HOLD))
		else $error("speed and run mode disagree on hold");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= RAMP_LAST)
		else $error("ramp index beyond table");

	a_cruise_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(speed_q == SPD_CONST) |-> (idx_q == RAMP_CRUISE))
		else $error("cruise with wrong ramp index");

	a_step_current: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_d) |=> current_q)
		else $error("step issued with current off");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !step_d) |=> $stable(phase_q) && $stable(pos_q))
		else $error("phase or position moved without a step");

endmodule

// ----- rtl/stepper_door_ramp_controller.sv -----
// ---------------------------------------------------------------------------
// stepper_door_ramp_controller: trapezoidal step-rate generator for a door
//
// Channels: cmd (sink) carries one control tick per item, with an optional
// open/close command; res (source) returns one result item per tick with the
// step flag, motor phase, current enable, position and speed state.
// Configuration: APB port, 64-bit data, register i at byte address 8*i
// (accel periods, cruise period, decel periods, far and home position).
// pready is tied high; write only while the block is idle.
// Path: an accepted tick is registered in the input register; on advance it
// updates the ramp state and its result loads the result register that drives
// res. Throughput: one tick per cycle while res is taken, as the state update
// between the input and result registers is combinational.
// Stall: while res is not taken the result register holds; one more tick
// waits in the input register, then cmd.ready drops until res is taken.
// Reset: all ramp state clears to hold at position 0, phase 0, current off;
// configuration returns to its reset values; both registers empty.
// ---------------------------------------------------------------------------
module stepper_door_ramp_controller
	import sdr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	sdr_cmd_if.sink               cmd,
	sdr_res_if.source             res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	sdr_cfg_t    cfg;
	sdr_result_t result_d;
	sdr_result_t result_q;

	logic valid_s1;
	logic cmd_valid_s1;
	logic cmd_open_s1;
	logic res_valid_q;
	logic advance;

	sdr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance the registered tick into the result register when it is free
	// or being taken this cycle
	assign advance   = valid_s1 & (~res_valid_q | res.ready);
	// take a new tick whenever the input register is empty or empties this cycle
	assign cmd.ready = ~valid_s1 | advance;

	sdr_ramp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.advance   (advance),
		.cmd_valid (cmd_valid_s1),
		.cmd_open  (cmd_open_s1),
		.result    (result_d)
	);

	// input register: hold the tick until the core consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready) begin
			cmd_valid_s1 <= cmd.cmd_valid;
			cmd_open_s1  <= cmd.cmd_open;
		end
	end

	// result register: load on advance, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.step_taken = result_q.step_taken;
	assign res.phase      = result_q.phase;
	assign res.current_on = result_q.current_on;
	assign res.position   = result_q.position;
	assign res.motion     = result_q.motion;

endmodule
